// ===== sv/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console character engine: screen
// geometry, request and response payloads, microcode steps and control word.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // screen geometry
   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int CELLS    = COLUMNS * ROWS;
   localparam int TAB_STOP = 8;

   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int CELL_W = 16;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int LOC_W  = 11;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_GOTO  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  char_code;
      logic [6:0]  pos_column;
      logic [4:0]  pos_row;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_location;
      logic [15:0] cell_data;
   } rsp_type;

   // microcode steps
   typedef enum logic [3:0] {
      S_IDLE    = 4'd0,
      S_PUT     = 4'd1,
      S_SCR_RD  = 4'd2,
      S_SCR_WR  = 4'd3,
      S_BLANK   = 4'd4,
      S_SCR_END = 4'd5,
      S_GOTO    = 4'd6,
      S_CLR     = 4'd7,
      S_READ    = 4'd8,
      S_RST     = 4'd9,
      S_RSP     = 4'd10
   } step_type;

   typedef enum logic [1:0] {
      WD_CHAR,
      WD_BLANK,
      WD_RDATA
   } wd_sel_type;

   typedef enum logic {
      WA_CURSOR,
      WA_PTR
   } wa_sel_type;

   typedef enum logic {
      RA_SCROLL,
      RA_INDEX
   } ra_sel_type;

   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_CLEAR,
      PTR_INC
   } ptr_op_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_PUT,
      CUR_GOTO,
      CUR_HOME,
      CUR_LAST_ROW
   } cur_op_type;

   typedef enum logic [2:0] {
      C_NONE,
      C_DISPATCH,
      C_ROW_OVF,
      C_SCR_END,
      C_CELL_END
   } cond_type;

   // one control word of the microprogram
   typedef struct packed {
      logic       ram_we;
      wd_sel_type wd_sel;
      wa_sel_type wa_sel;
      ra_sel_type ra_sel;
      ptr_op_type ptr_op;
      cur_op_type cur_op;
      logic       rsp_load;
      cond_type   cond;
      step_type   next_a;
      step_type   next_b;
   } ctl_type;

   // datapath status used for branching
   typedef struct packed {
      logic row_ovf;
      logic scr_end;
      logic cell_end;
   } sts_type;

endpackage

// ===== sv/text_console_char_engine_unit.sv =====
// A put without scroll, a goto and a read each run one microcode step and then the response
// step before the response strobe. A new request is taken only once back in the idle step.
// A put that scrolls reads and writes back each cell above the last row, then blanks the
// last row; clear blanks every cell in turn. The receiver cannot stall.
// Reset: synchronous; busy stays high while the store is blanked
// with attribute 0x0F. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// text_console_char_engine_unit
// Text-mode console engine: an 80x25 cell store with cursor, driven by a
// small microprogram for put, goto, clear and read requests.
// ----------------------------------------------------------------------------
module text_console_char_engine_unit import tcce_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [ATTR_W-1:0] csr_wdata
);

   ctl_type ctl;
   sts_type sts;
   logic    accept;

   assign accept = start && !busy;

   // sequencer
   tcce_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .op    (req_data.operation),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy)
   );

   // datapath
   tcce_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== sv/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/tcce_seq.sv =====
// ----------------------------------------------------------------------------
// tcce_seq
// Microcode sequencer: step counter, control store and branch logic.
// ----------------------------------------------------------------------------
module tcce_seq import tcce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  op_type  op,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    busy
);

   step_type upc_ff;
   step_type upc_in;
   logic     taken;

   // control store
   function automatic ctl_type ucode(input step_type s);
      ctl_type w;
      w = '{ram_we: 1'b0, wd_sel: WD_BLANK, wa_sel: WA_PTR, ra_sel: RA_SCROLL,
            ptr_op: PTR_HOLD, cur_op: CUR_HOLD, rsp_load: 1'b0, cond: C_NONE,
            next_a: S_IDLE, next_b: S_IDLE};
      unique case (s)
         S_IDLE: begin
            w.ptr_op = PTR_CLEAR;
            w.cond   = C_DISPATCH;
         end
         S_PUT: begin
            w.ram_we = 1'b1;
            w.wd_sel = WD_CHAR;
            w.wa_sel = WA_CURSOR;
            w.cur_op = CUR_PUT;
            w.cond   = C_ROW_OVF;
            w.next_a = S_RSP;
            w.next_b = S_SCR_RD;
         end
         S_SCR_RD: begin
            w.next_a = S_SCR_WR;
         end
         S_SCR_WR: begin
            w.ram_we = 1'b1;
            w.wd_sel = WD_RDATA;
            w.ptr_op = PTR_INC;
            w.cond   = C_SCR_END;
            w.next_a = S_SCR_RD;
            w.next_b = S_BLANK;
         end
         S_BLANK: begin
            w.ram_we = 1'b1;
            w.ptr_op = PTR_INC;
            w.cond   = C_CELL_END;
            w.next_a = S_BLANK;
            w.next_b = S_SCR_END;
         end
         S_SCR_END: begin
            w.cur_op = CUR_LAST_ROW;
            w.next_a = S_RSP;
         end
         S_GOTO: begin
            w.cur_op = CUR_GOTO;
            w.next_a = S_RSP;
         end
         S_CLR: begin
            w.ram_we = 1'b1;
            w.ptr_op = PTR_INC;
            w.cur_op = CUR_HOME;
            w.cond   = C_CELL_END;
            w.next_a = S_CLR;
            w.next_b = S_RSP;
         end
         S_READ: begin
            w.ra_sel = RA_INDEX;
            w.next_a = S_RSP;
         end
         S_RST: begin
            w.ram_we = 1'b1;
            w.ptr_op = PTR_INC;
            w.cond   = C_CELL_END;
            w.next_a = S_RST;
            w.next_b = S_IDLE;
         end
         S_RSP: begin
            w.rsp_load = 1'b1;
         end
         default: begin
            w.next_a = S_IDLE;
         end
      endcase
      return w;
   endfunction

   assign ctl  = ucode(upc_ff);
   assign busy = (upc_ff != S_IDLE);

   // branch condition
   always_comb begin
      unique case (ctl.cond)
         C_ROW_OVF:  taken = sts.row_ovf;
         C_SCR_END:  taken = sts.scr_end;
         C_CELL_END: taken = sts.cell_end;
         default:    taken = 1'b0;
      endcase
   end

   // next step, with opcode dispatch from idle
   always_comb begin
      upc_in = taken ? ctl.next_b : ctl.next_a;
      if (ctl.cond == C_DISPATCH && start) begin
         unique case (op)
            OP_PUT:   upc_in = S_PUT;
            OP_GOTO:  upc_in = S_GOTO;
            OP_CLEAR: upc_in = S_CLR;
            OP_READ:  upc_in = S_READ;
            default:  upc_in = S_IDLE;
         endcase
      end
   end

   // step counter, reset enters the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_RST;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== sv/tcce_dp.sv =====
// ----------------------------------------------------------------------------
// tcce_dp
// Datapath: request latch, cursor, sweep pointer, attribute registers,
// screen store and response registers; all but the latch and attributes follow the control word.
// ----------------------------------------------------------------------------
module tcce_dp import tcce_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  req_type            req_data,
   input  logic               csr_we,
   input  logic [ATTR_W-1:0]  csr_wdata,
   input  ctl_type            ctl,
   output sts_type            sts,
   output logic               rsp_strobe,
   output rsp_type            rsp_data
);

   req_type             req_ff;
   logic [ATTR_W-1:0]   attr_ff;
   logic [ATTR_W-1:0]   fill_attr_ff;
   logic [COL_W-1:0]    col_ff;
   logic [COL_W-1:0]    col_in;
   logic [ROW_W-1:0]    row_ff;
   logic [ROW_W-1:0]    row_in;
   logic [ADDR_W-1:0]   ptr_ff;
   logic                rsp_strobe_ff;
   rsp_type             rsp_data_ff;

   logic [COL_W:0]      put_col;
   logic [ROW_W-1:0]    put_row;
   logic [COL_W-1:0]    put_col_fin;
   logic [ROW_W-1:0]    put_row_fin;
   logic                printable;
   logic [CHAR_W-1:0]   ch;
   logic [ADDR_W-1:0]   cur_addr;
   logic                idx_ok;
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [CELL_W-1:0]   ram_wdata;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [CELL_W-1:0]   ram_rdata;

   assign ch        = req_ff.char_code;
   assign printable = (ch[CHAR_W-1] == 1'b0) && (ch >= CH_SPACE);
   assign cur_addr  = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(COLUMNS)) + ADDR_W'(col_ff);
   assign idx_ok    = (int'(req_ff.cell_index) < CELLS);

   // cursor motion for a put request
   always_comb begin
      put_col = {1'b0, col_ff};
      put_row = row_ff;
      priority if (ch == CH_BS) begin
         if (col_ff != '0) begin
            put_col = put_col - (COL_W+1)'(1);
         end
      end else if (ch == CH_TAB) begin
         put_col = (put_col + (COL_W+1)'(TAB_STOP)) & ~((COL_W+1)'(TAB_STOP - 1));
      end else if (ch == CH_CR) begin
         put_col = '0;
      end else if (ch == CH_LF) begin
         put_col = '0;
         put_row = row_ff + ROW_W'(1);
      end else if (printable) begin
         put_col = put_col + (COL_W+1)'(1);
      end else begin
         put_col = {1'b0, col_ff};
      end
      if (int'(put_col) >= COLUMNS) begin
         put_col_fin = '0;
         put_row_fin = put_row + ROW_W'(1);
      end else begin
         put_col_fin = put_col[COL_W-1:0];
         put_row_fin = put_row;
      end
   end

   // next cursor
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      unique case (ctl.cur_op)
         CUR_PUT: begin
            col_in = put_col_fin;
            row_in = put_row_fin;
         end
         CUR_GOTO: begin
            col_in = (int'(req_ff.pos_column) > COLUMNS - 1) ?
                     COL_W'(COLUMNS - 1) : COL_W'(req_ff.pos_column);
            row_in = (int'(req_ff.pos_row) > ROWS - 1) ?
                     ROW_W'(ROWS - 1) : ROW_W'(req_ff.pos_row);
         end
         CUR_HOME: begin
            col_in = '0;
            row_in = '0;
         end
         CUR_LAST_ROW: begin
            row_in = ROW_W'(ROWS - 1);
         end
         default: begin
            col_in = col_ff;
         end
      endcase
   end

   // branch status
   assign sts.row_ovf  = (int'(put_row_fin) >= ROWS);
   assign sts.scr_end  = (ptr_ff == ADDR_W'(CELLS - COLUMNS - 1));
   assign sts.cell_end = (ptr_ff == ADDR_W'(CELLS - 1));

   // store ports
   assign ram_we    = ctl.ram_we && ((ctl.wd_sel != WD_CHAR) || printable);
   assign ram_waddr = (ctl.wa_sel == WA_CURSOR) ? cur_addr : ptr_ff;
   assign ram_raddr = (ctl.ra_sel == RA_INDEX) ?
                      (idx_ok ? ADDR_W'(req_ff.cell_index) : '0) :
                      ptr_ff + ADDR_W'(COLUMNS);

   always_comb begin
      unique case (ctl.wd_sel)
         WD_CHAR:  ram_wdata = {fill_attr_ff, ch};
         WD_RDATA: ram_wdata = ram_rdata;
         default:  ram_wdata = {fill_attr_ff, CH_SPACE};
      endcase
   end

   tcce_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // request latch
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   // attribute, cursor, pointer and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff       <= ATTR_RESET;
         fill_attr_ff  <= ATTR_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         ptr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            attr_ff <= csr_wdata;
         end
         if (accept) begin
            fill_attr_ff <= attr_ff;
         end
         col_ff <= col_in;
         row_ff <= row_in;
         unique case (ctl.ptr_op)
            PTR_CLEAR: ptr_ff <= '0;
            PTR_INC:   ptr_ff <= ptr_ff + ADDR_W'(1);
            default:   ptr_ff <= ptr_ff;
         endcase
         rsp_strobe_ff <= ctl.rsp_load;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_data_ff.cursor_location <= LOC_W'(cur_addr);
         rsp_data_ff.cell_data <= (req_ff.operation == OP_READ && idx_ok) ?
                                  ram_rdata : '0;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== verif/text_console_char_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_char_engine_unit_tb
// Self-checking bench for the text console engine. A shadow copy of the cell
// store, cursor and attribute predicts every response; directed requests hit
// the control codes, clamping and scrolling, then random text lines and noise
// run under several attribute settings and sender idle rates.
// ----------------------------------------------------------------------------
module text_console_char_engine_unit_tb import tcce_pkg::*; ();

   localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;
   localparam int MAX_INDEX = 2047;
   localparam longint TIMEOUT_NS = 64'd200_000_000;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_strobe;
   rsp_type           rsp_data;
   logic              csr_we;
   logic [ATTR_W-1:0] csr_wdata;

   // shadow console state
   logic [CELL_W-1:0] shadow_cells [CELLS];
   int                shadow_col;
   int                shadow_row;
   logic [ATTR_W-1:0] shadow_attr;

   rsp_type cursor_cell_queue [$];
   rsp_type head_rsp;
   int      items_sent;
   int      fail_count;
   int      sender_idle_pct;

   text_console_char_engine_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // apply one request to the shadow console, return the response it yields
   function automatic rsp_type console_step(input req_type r);
      rsp_type resp;
      int      col;
      int      row;
      int      idx;
      int      i;
      col = shadow_col;
      row = shadow_row;
      resp.cell_data = '0;
      case (r.operation)
         OP_PUT: begin
            if (r.char_code == CH_BS) begin
               if (col != 0) col--;
            end else if (r.char_code == CH_TAB) begin
               col = (col + TAB_STOP) & ~(TAB_STOP - 1);
            end else if (r.char_code == CH_CR) begin
               col = 0;
            end else if (r.char_code == CH_LF) begin
               col = 0;
               row++;
            end else if (r.char_code >= CH_SPACE && r.char_code <= CH_DEL) begin
               idx = row * COLUMNS + col;
               if (idx < CELLS) shadow_cells[ADDR_W'(idx)] = {shadow_attr, r.char_code};
               col++;
            end
            // column wrap
            if (col >= COLUMNS) begin
               col = 0;
               row++;
            end
            // scroll up one row
            if (row >= ROWS) begin
               for (i = 0; i < CELLS - COLUMNS; i++)
                  shadow_cells[ADDR_W'(i)] = shadow_cells[ADDR_W'(i + COLUMNS)];
               for (i = CELLS - COLUMNS; i < CELLS; i++)
                  shadow_cells[ADDR_W'(i)] = {shadow_attr, CH_SPACE};
               row = ROWS - 1;
            end
         end
         OP_GOTO: begin
            col = (int'(r.pos_column) > COLUMNS - 1) ? COLUMNS - 1 : int'(r.pos_column);
            row = (int'(r.pos_row) > ROWS - 1) ? ROWS - 1 : int'(r.pos_row);
         end
         OP_CLEAR: begin
            for (i = 0; i < CELLS; i++) shadow_cells[ADDR_W'(i)] = {shadow_attr, CH_SPACE};
            col = 0;
            row = 0;
         end
         default: begin
            if (int'(r.cell_index) < CELLS) resp.cell_data = shadow_cells[r.cell_index];
         end
      endcase
      shadow_col = col;
      shadow_row = row;
      resp.cursor_location = LOC_W'(row * COLUMNS + col);
      return resp;
   endfunction

   task automatic note_failure(input string what);
      fail_count++;
      if (fail_count <= 10) $display("%s", what);
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (cursor_cell_queue.size() == 0) begin
            note_failure($sformatf("unexpected response at %0t: cursor %0d cell %h",
                                   $time, rsp_data.cursor_location, rsp_data.cell_data));
         end else begin
            head_rsp = cursor_cell_queue.pop_front();
            if (rsp_data.cursor_location !== head_rsp.cursor_location)
               note_failure($sformatf("cursor_location mismatch at %0t: expected %0d actual %0d",
                                      $time, head_rsp.cursor_location,
                                      rsp_data.cursor_location));
            if (rsp_data.cell_data !== head_rsp.cell_data)
               note_failure($sformatf("cell_data mismatch at %0t: expected %h actual %h",
                                      $time, head_rsp.cell_data, rsp_data.cell_data));
         end
      end
   end

   // drive one request and wait until it is taken
   task automatic send_request(input req_type r);
      rsp_type resp;
      @(negedge clock);
      start    = 1'b1;
      req_data = r;
      @(posedge clock);
      while (busy) @(posedge clock);
      resp = console_step(r);
      cursor_cell_queue.push_back(resp);
      items_sent++;
      // random gap before the next request
      if ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(7)) @(negedge clock);
      end
   endtask

   // all fields random, operation fixed
   function automatic req_type noise_fields(input op_type op);
      req_type r;
      r.operation  = op;
      r.char_code  = CHAR_W'($urandom);
      r.pos_column = 7'($urandom);
      r.pos_row    = 5'($urandom);
      r.cell_index = 11'($urandom);
      return r;
   endfunction

   task automatic put_char(input logic [CHAR_W-1:0] ch);
      req_type r;
      r = noise_fields(OP_PUT);
      r.char_code = ch;
      send_request(r);
   endtask

   task automatic goto_pos(input logic [6:0] col, input logic [4:0] row);
      req_type r;
      r = noise_fields(OP_GOTO);
      r.pos_column = col;
      r.pos_row    = row;
      send_request(r);
   endtask

   task automatic clear_screen();
      send_request(noise_fields(OP_CLEAR));
   endtask

   task automatic read_cell(input logic [10:0] idx);
      req_type r;
      r = noise_fields(OP_READ);
      r.cell_index = idx;
      send_request(r);
   endtask

   // drop start and let every response come back
   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (cursor_cell_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_text_attribute(input logic [ATTR_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      shadow_attr = value;
   endtask

   task automatic test_reset_contents();
      read_cell(11'd0);
      read_cell(11'(CELLS - 1));
      read_cell(11'(MAX_INDEX));
   endtask

   task automatic test_put_codes();
      put_char(8'h41);
      put_char(CH_DEL);
      put_char(CH_BS);
      put_char(CH_CR);
      // backspace at column 0 stays put
      put_char(CH_BS);
      put_char(CH_TAB);
      // ignored control and high bytes
      put_char(8'h00);
      put_char(8'h1F);
      put_char(8'h80);
      put_char(8'hFF);
      put_char(CH_LF);
      read_cell(11'd1);
   endtask

   task automatic test_goto_clamp();
      // clamp to the last cell, then wrap into a scroll
      goto_pos(7'h7F, 5'h1F);
      put_char(8'h5A);
      read_cell(11'(CELLS - 1 - COLUMNS));
      // tab past the last column, then line feed on the last row
      goto_pos(7'(COLUMNS - 4), 5'(ROWS - 1));
      put_char(CH_TAB);
      put_char(CH_LF);
   endtask

   task automatic test_attribute_clear();
      set_text_attribute(8'h00);
      put_char(8'h21);
      clear_screen();
      read_cell(11'(CELLS - 1));
   endtask

   task automatic random_item();
      int p;
      int idx;
      p = $urandom_range(99);
      if (p < 38) begin
         put_char(CHAR_W'($urandom_range(CH_SPACE, CH_DEL)));
      end else if (p < 58) begin
         case ($urandom_range(5))
            0:       put_char(CH_BS);
            1:       put_char(CH_TAB);
            2:       put_char(CH_CR);
            3:       put_char(CH_LF);
            4:       put_char(CHAR_W'($urandom_range(0, 31)));
            default: put_char(CHAR_W'($urandom_range(128, 255)));
         endcase
      end else if (p < 76) begin
         goto_pos(7'($urandom_range(127)), 5'($urandom_range(31)));
      end else if (p < 99) begin
         // reads near the cursor, anywhere, or past the store
         case ($urandom_range(9))
            0, 1, 2: begin
               idx = shadow_row * COLUMNS + shadow_col - int'($urandom_range(12));
               if (idx < 0) idx = 0;
            end
            9:       idx = int'($urandom_range(CELLS, MAX_INDEX));
            default: idx = int'($urandom_range(CELLS - 1));
         endcase
         read_cell(11'(idx));
      end else begin
         clear_screen();
      end
   endtask

   // text lines with random content, mixed with noise and broken lines
   task automatic run_random_phase(input int count);
      int target;
      int len;
      int k;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(99) < 35) begin
            if ($urandom_range(2) == 0)
               goto_pos(7'($urandom_range(127)), 5'($urandom_range(31)));
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 16);
            for (k = 0; k < len; k++) put_char(CHAR_W'($urandom_range(CH_SPACE, CH_DEL)));
            case ($urandom_range(5))
               0, 1, 2: begin
                  put_char(CH_CR);
                  put_char(CH_LF);
               end
               3:       put_char(CH_LF);
               4:       put_char(CH_BS);
               default: ;
            endcase
         end else begin
            random_item();
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      items_sent      = 0;
      fail_count      = 0;
      sender_idle_pct = 0;
      shadow_attr     = ATTR_RESET;
      shadow_col      = 0;
      shadow_row      = 0;
      for (int i = 0; i < CELLS; i++) shadow_cells[ADDR_W'(i)] = {ATTR_RESET, CH_SPACE};
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_reset_contents();
      test_put_codes();
      test_goto_clamp();
      test_attribute_clear();

      set_text_attribute(8'hFF);
      sender_idle_pct = 0;
      run_random_phase(160);

      set_text_attribute(ATTR_W'($urandom));
      sender_idle_pct = 77;
      run_random_phase(160);

      set_text_attribute(ATTR_RESET);
      sender_idle_pct = 14;
      run_random_phase(170);

      set_text_attribute(ATTR_W'($urandom));
      sender_idle_pct = 0;
      run_random_phase(160);

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
